/* design/blr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// No dependencies; blr_front, blr_back and the top level import this package.
package blr_pkg;

    localparam int IN_COORD_W = 16;
    localparam int COLOR_W    = 32;
    localparam int ADDR_W     = 20;

    // Request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic                         opcode;
        logic signed [IN_COORD_W-1:0] start_x;
        logic signed [IN_COORD_W-1:0] start_y;
        logic signed [IN_COORD_W-1:0] end_x;
        logic signed [IN_COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]           draw_color;
    } cmd_t;

    typedef struct packed {
        logic                         pixel_valid;
        logic signed [IN_COORD_W-1:0] pixel_x;
        logic signed [IN_COORD_W-1:0] pixel_y;
        logic [ADDR_W-1:0]            pixel_address;
        logic                         write_enable;
        logic [COLOR_W-1:0]           pixel_color;
        logic                         last_pixel;
    } pixel_t;

endpackage

/* design/blr_chan_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload per request.
// Payload type is set per instance; no package dependency.
interface blr_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/blr_front.sv */
`timescale 1ns / 1ps
// Front end: decodes each request and precomputes line setup for loads.
// Depends on blr_pkg and blr_chan_if.
module blr_front #(
    parameter int  COORD_BITS = 16,
    parameter type entry_t    = logic
) (
    blr_chan_if.sink   cmd,
    blr_chan_if.source entry
);
    import blr_pkg::*;

    localparam int EXT_W   = (COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W;
    localparam int DELTA_W = COORD_BITS + 1;
    localparam int ERR_W   = COORD_BITS + 3;

    // Reinterpret the raw field bits as a COORD_BITS signed coordinate
    function automatic logic signed [COORD_BITS-1:0] to_coord(
        input logic [IN_COORD_W-1:0] raw
    );
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(raw);
        return ext[COORD_BITS-1:0];
    endfunction

    logic signed [COORD_BITS-1:0] sx, sy, tx, ty;
    logic signed [DELTA_W-1:0]    diff_x, diff_y;
    logic [DELTA_W-1:0]           abs_x, abs_y;
    entry_t                       ent;

    always_comb
    begin
        sx = to_coord($unsigned(cmd.payload.start_x));
        sy = to_coord($unsigned(cmd.payload.start_y));
        tx = to_coord($unsigned(cmd.payload.end_x));
        ty = to_coord($unsigned(cmd.payload.end_y));

        diff_x = {sx[COORD_BITS-1], sx} - {tx[COORD_BITS-1], tx};
        diff_y = {sy[COORD_BITS-1], sy} - {ty[COORD_BITS-1], ty};
        abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
        abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);

        ent             = '0;
        ent.is_step     = (cmd.payload.opcode == OP_STEP);
        ent.line_active = (sx != tx) || (sy != ty);
        ent.cur_x       = sx;
        ent.cur_y       = sy;
        ent.target_x    = tx;
        ent.target_y    = ty;
        ent.delta_x     = abs_x;
        ent.delta_y     = abs_y;
        ent.error_term  = ERR_W'(abs_x) - ERR_W'(abs_y);
        ent.line_color  = cmd.payload.draw_color;
    end

    assign entry.valid   = cmd.valid;
    assign entry.payload = ent;
    assign cmd.ready     = entry.ready;

endmodule

/* design/blr_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between the front end and the step engine.
// Depends on blr_chan_if.
module blr_queue #(
    parameter type entry_t = logic
) (
    input  logic       clk,
    input  logic       rst_n,
    blr_chan_if.sink   push,
    blr_chan_if.source pop
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push.ready  = (count_reg != CNT_W'(DEPTH));
    assign pop.valid   = (count_reg != '0);
    assign pop.payload = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && push.ready;
    assign do_pop  = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.payload;
        end
    end

endmodule

/* design/blr_back.sv */
`timescale 1ns / 1ps
// Step engine: holds line state, runs a Bresenham step per pixel request
// and registers the pixel. Depends on blr_pkg and blr_chan_if.
module blr_back #(
    parameter int  SCREEN_W   = 1024,
    parameter int  SCREEN_H   = 768,
    parameter int  COORD_BITS = 16,
    parameter type entry_t    = logic
) (
    input  logic       clk,
    input  logic       rst_n,
    blr_chan_if.sink   op,
    blr_chan_if.source pixel
);
    import blr_pkg::*;

    localparam int DELTA_W = COORD_BITS + 1;
    localparam int ERR_W   = COORD_BITS + 3;
    localparam int E2_W    = COORD_BITS + 4;
    localparam int PROD_W  = $clog2(SCREEN_W * SCREEN_H);
    localparam logic signed [E2_W-1:0] E2_ZERO = '0;

    // Line state
    logic                         line_active_reg, line_active_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic signed [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [DELTA_W-1:0]           delta_x_reg, delta_x_next;
    logic [DELTA_W-1:0]           delta_y_reg, delta_y_next;
    logic signed [ERR_W-1:0]      error_reg, error_next;
    logic [COLOR_W-1:0]           color_reg, color_next;

    // Output register
    logic   out_valid_reg, out_valid_next;
    pixel_t out_reg, out_next;

    // Step datapath
    logic signed [E2_W-1:0]       e2, dx_s, dy_s, err_sum;
    logic                         step_x, step_y, last;
    logic signed [COORD_BITS-1:0] nx, ny;
    logic                         on_screen;
    logic [PROD_W-1:0]            prod;
    logic                         take;
    entry_t                       ent;

    assign ent      = op.payload;
    assign op.ready = !ent.is_step || !out_valid_reg || pixel.ready;
    assign take     = op.valid && op.ready;

    always_comb
    begin
        dx_s    = E2_W'(delta_x_reg);
        dy_s    = E2_W'(delta_y_reg);
        e2      = E2_W'(error_reg) <<< 1;
        step_x  = (e2 >= -dy_s);
        step_y  = (e2 <= dx_s);
        err_sum = E2_W'(error_reg) - (step_x ? dy_s : E2_ZERO) + (step_y ? dx_s : E2_ZERO);

        nx = cur_x_reg;
        if (step_x)
        begin
            nx = (cur_x_reg < target_x_reg) ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1;
        end
        ny = cur_y_reg;
        if (step_y)
        begin
            ny = (cur_y_reg < target_y_reg) ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1;
        end
        last = (nx == target_x_reg) && (ny == target_y_reg);

        on_screen = !cur_x_reg[COORD_BITS-1] && (int'(cur_x_reg) < SCREEN_W)
                 && !cur_y_reg[COORD_BITS-1] && (int'(cur_y_reg) < SCREEN_H);
        prod      = PROD_W'($unsigned(cur_y_reg)) * PROD_W'(SCREEN_W)
                  + PROD_W'($unsigned(cur_x_reg));
    end

    always_comb
    begin
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        error_next       = error_reg;
        color_next       = color_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;

        if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take && !ent.is_step)
        begin
            line_active_next = ent.line_active;
            cur_x_next       = ent.cur_x;
            cur_y_next       = ent.cur_y;
            target_x_next    = ent.target_x;
            target_y_next    = ent.target_y;
            delta_x_next     = ent.delta_x;
            delta_y_next     = ent.delta_y;
            error_next       = ent.error_term;
            color_next       = ent.line_color;
        end
        else if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (line_active_reg)
            begin
                out_next.pixel_valid   = 1'b1;
                out_next.pixel_x       = IN_COORD_W'(cur_x_reg);
                out_next.pixel_y       = IN_COORD_W'(cur_y_reg);
                out_next.pixel_address = on_screen ? ADDR_W'(prod) : '0;
                out_next.write_enable  = on_screen;
                out_next.pixel_color   = color_reg;
                out_next.last_pixel    = last;
                cur_x_next             = nx;
                cur_y_next             = ny;
                error_next             = ERR_W'(err_sum);
                // drop the line once the end point is reached
                line_active_next       = !last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        target_x_reg <= target_x_next;
        target_y_reg <= target_y_next;
        delta_x_reg  <= delta_x_next;
        delta_y_reg  <= delta_y_next;
        error_reg    <= error_next;
        color_reg    <= color_next;
        out_reg      <= out_next;
    end

    assign pixel.valid   = out_valid_reg;
    assign pixel.payload = out_reg;

endmodule

/* design/bresenham_line_raster.sv */
`timescale 1ns / 1ps
// Line rasterizer top level: front end, request queue and step engine.
// Depends on blr_pkg, blr_chan_if, blr_front, blr_queue and blr_back.
//
//   Channel  Dir  Payload       Carries
//   cmd      in   blr_pkg::cmd_t   load a line (opcode 0) or request a pixel (1)
//   pixel    out  blr_pkg::pixel_t one pixel per pixel request, none per load
//
// One request per cycle sustained while the pixel output is not stalled;
// the step engine updates the line state once per accepted request.
// A pixel request's result is valid on the cycle after the queue hands it over.
// Reset clears the queue, the output valid flag and the active-line flag.
// A stalled pixel output blocks pixel requests at the queue head; the
// two-entry queue then fills and cmd.ready drops. Loads pass a stalled output.
module bresenham_line_raster #(
    parameter int SCREEN_W   = 1024,
    parameter int SCREEN_H   = 768,
    parameter int COORD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    blr_chan_if.sink   cmd,
    blr_chan_if.source pixel
);
    import blr_pkg::*;

    localparam int DELTA_W = COORD_BITS + 1;
    localparam int ERR_W   = COORD_BITS + 3;

    typedef struct packed {
        logic                         is_step;
        logic                         line_active;
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic [DELTA_W-1:0]           delta_x;
        logic [DELTA_W-1:0]           delta_y;
        logic signed [ERR_W-1:0]      error_term;
        logic [COLOR_W-1:0]           line_color;
    } op_entry_t;

    blr_chan_if #(.payload_t(op_entry_t)) fq_in ();
    blr_chan_if #(.payload_t(op_entry_t)) fq_out ();

    blr_front #(
        .COORD_BITS (COORD_BITS),
        .entry_t    (op_entry_t)
    ) u_front (
        .cmd   (cmd),
        .entry (fq_in)
    );

    blr_queue #(
        .entry_t (op_entry_t)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_in),
        .pop   (fq_out)
    );

    blr_back #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .COORD_BITS (COORD_BITS),
        .entry_t    (op_entry_t)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (fq_out),
        .pixel (pixel)
    );

    a_load_never_held: assert property (@(posedge clk) disable iff (!rst_n)
        fq_out.valid && !fq_out.payload.is_step |-> fq_out.ready)
        else $error("load request stalled at queue head");

    a_step_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        fq_out.valid && fq_out.ready && fq_out.payload.is_step |=> pixel.valid)
        else $error("pixel request consumed without a result");

    a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> fq_out.valid)
        else $error("accepted request missing from queue");

endmodule
